FILE: src/lje_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lje_pkg: shared types and constants
// State encoding, command codes, register indexes and the handshake
// structs of the iterative multiplier and divider.
// ----------------------------------------------------------------------------
package lje_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REG_BOX_LENGTH     = 2'd0;
  localparam logic [1:0] REG_INV_BOX_LENGTH = 2'd1;
  localparam logic [1:0] REG_CUTOFF_SQ      = 2'd2;
  localparam logic [1:0] REG_PARTICLE_COUNT = 2'd3;

  localparam logic signed [47:0] E_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] E_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOADI,
    ST_FETCH,
    ST_AXIS,
    ST_WAIT_N,
    ST_WAIT_NB,
    ST_WAIT_SQ,
    ST_CUT,
    ST_WAIT_DIV,
    ST_WAIT_Q2,
    ST_WAIT_Q3,
    ST_WAIT_Q6,
    ST_ACC,
    ST_OUT
  } lje_state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/lje_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lje_mul: iterative 64x64 multiplier
// Shift-add, one bit of b per cycle; stops as soon as b runs out of ones.
// ----------------------------------------------------------------------------
module lje_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lje_pkg::mul_req_t req_i,
  output lje_pkg::mul_rsp_t rsp_o
);

  logic         run_q;
  logic [127:0] acc_q;
  logic [127:0] a_q;
  logic [63:0]  b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (req_i.start) begin
      run_q <= 1'b1;
    end else if (run_q && (b_q == '0)) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= {64'd0, req_i.a};
      b_q   <= req_i.b;
    end else if (run_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[126:0], 1'b0};
      b_q <= {1'b0, b_q[63:1]};
    end
  end

  assign rsp_o.done = run_q && (b_q == '0);
  assign rsp_o.prod = acc_q;

endmodule

FILE: src/lje_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lje_div: reciprocal divider
// Restoring division of 2^(2F) by a 64-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lje_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lje_pkg::div_req_t req_i,
  output lje_pkg::div_rsp_t rsp_o
);

  localparam int DivSteps = 2 * FRAC_BITS + 1;
  localparam int CntW     = $clog2(DivSteps);

  logic            run_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [63:0]     rem_q;
  logic [63:0]     quo_q;
  logic [63:0]     dvs_q;
  logic [64:0]     trial;
  logic            fits;

  always_comb begin
    trial = {rem_q, (cnt_q == CntW'(DivSteps - 1))};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
      end else if (run_q && (cnt_q == '0)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // remainder stays below the divisor, so 64 bits hold it
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      cnt_q <= CntW'(DivSteps - 1);
      rem_q <= '0;
      quo_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      rem_q <= fits ? 64'(trial - {1'b0, dvs_q}) : trial[63:0];
      quo_q <= {quo_q[62:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: src/lennard_jones_particle_energy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lennard_jones_particle_energy: Lennard-Jones energy of one stored particle
// Position store plus a sequencer that sums 4(r^-12 - r^-6) over partners.
// ----------------------------------------------------------------------------
// A write item (cmd 0) stores x, y, z of one particle; it yields no result.
// A query item (cmd 1) yields one result: the saturating Q31.16 energy of
// that particle against every other written particle below particle_count
// whose squared (minimum-image folded) distance is under the cutoff. The
// block takes one item at a time and holds in_stall_o high while a query
// runs. A query's time grows with each index skipped, each partner's control
// and the runs of the multiplier and divider. A multiplier run stops once its
// second operand has no significant bits left; there are three runs per axis
// with folding or one without, and three more for the energy term, which,
// like the run of the reciprocal divider, only a partner inside the cutoff at
// nonzero distance pays. Positions sit in a single-port memory; written bits
// live in flops and are cleared by reset.
// ----------------------------------------------------------------------------
module lennard_jones_particle_energy #(
  parameter int MAX_PARTICLES       = 256,
  parameter int COORD_FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_wdata_i,
  // item input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [7:0]         particle_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] particle_energy_o,
  output logic               energy_saturated_o
);

  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int F  = COORD_FRACTION_BITS;
  localparam logic [63:0] RoundHalf = 64'd1 << (2 * F - 1);
  localparam logic [63:0] ImgCap    = 64'h1_0000_0000;
  localparam logic [63:0] MagCap    = 64'h4000_0000_0000_0000;
  localparam logic signed [63:0] DiffMax = 64'sh1FFF_FFFF_FFFF;
  localparam logic signed [63:0] DiffMin = -64'sh2000_0000_0000;

  // configuration registers
  logic [30:0] box_q, inv_q, cut_q;
  logic [8:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
      inv_q <= '0;
      cut_q <= '0;
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lje_pkg::REG_BOX_LENGTH:     box_q <= cfg_wdata_i;
        lje_pkg::REG_INV_BOX_LENGTH: inv_q <= cfg_wdata_i;
        lje_pkg::REG_CUTOFF_SQ:      cut_q <= cfg_wdata_i;
        lje_pkg::REG_PARTICLE_COUNT: cnt_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  lje_pkg::lje_state_e state_q, state_d;

  logic accept, idx_ok, wr_en, rd_en;
  logic [IW-1:0] in_idx, rd_addr;

  assign accept = in_valid_i && !in_stall_o;
  assign idx_ok = 32'(particle_index_i) < MAX_PARTICLES;
  assign in_idx = IW'(particle_index_i);
  assign wr_en  = accept && (cmd_i == lje_pkg::CMD_WRITE) && idx_ok;

  // position store and written bits
  logic [95:0] mem [MAX_PARTICLES];
  logic [95:0] rd_q;
  logic [MAX_PARTICLES-1:0] written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[in_idx] <= {pos_x_i, pos_y_i, pos_z_i};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en) begin
      written_q[in_idx] <= 1'b1;
    end
  end

  // working registers
  logic [IW-1:0]      idx_q;
  logic [CW-1:0]      j_q;
  logic [95:0]        pi_q;
  logic [1:0]         k_q;
  logic signed [32:0] d_q;
  logic [63:0]        r2_q, q_q, q3_q;
  logic               sat_q;
  logic signed [47:0] term_q, sum_q;
  logic               flag_q;

  lje_pkg::mul_req_t mul_req;
  lje_pkg::mul_rsp_t mul_rsp;
  lje_pkg::div_req_t div_req;
  lje_pkg::div_rsp_t div_rsp;

  lje_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  lje_div #(
    .FRAC_BITS (F)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // datapath helpers
  logic [CW-1:0]      cnt_eff;
  logic               j_end, j_skip;
  logic signed [31:0] pi_sel, pj_sel;
  logic signed [32:0] d_c;
  logic [32:0]        dmag_c;
  logic [63:0]        n_full, n_c;
  logic signed [65:0] f_c, fmag_c;
  logic [63:0]        mag_c;
  logic [63:0]        sq_c;
  logic               msat_c;
  logic [63:0]        mval_c;
  logic signed [63:0] diff_c;
  logic signed [48:0] sum_c;

  always_comb begin
    cnt_eff = (32'(cnt_q) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(cnt_q);
    j_end   = j_q >= cnt_eff;
    j_skip  = (j_q[IW-1:0] == idx_q) || !written_q[j_q[IW-1:0]];

    case (k_q)
      2'd0:    begin pi_sel = pi_q[95:64]; pj_sel = rd_q[95:64]; end
      2'd1:    begin pi_sel = pi_q[63:32]; pj_sel = rd_q[63:32]; end
      default: begin pi_sel = pi_q[31:0];  pj_sel = rd_q[31:0];  end
    endcase
    d_c    = 33'(pi_sel) - 33'(pj_sel);
    dmag_c = d_c[32] ? 33'(-d_c) : 33'(d_c);

    // nearest image count, rounded half away from zero on the magnitude
    n_full = (mul_rsp.prod[63:0] + RoundHalf) >> (2 * F);
    n_c    = (n_full > ImgCap) ? ImgCap : n_full;

    // folded difference, then clamped magnitude
    f_c    = d_q[32] ? (66'(d_q) + $signed({3'b000, mul_rsp.prod[62:0]}))
                     : (66'(d_q) - $signed({3'b000, mul_rsp.prod[62:0]}));
    fmag_c = f_c[65] ? -f_c : f_c;
    mag_c  = (|fmag_c[65:32]) ? 64'h0000_0000_FFFF_FFFF : {32'd0, fmag_c[31:0]};

    sq_c = mul_rsp.prod[63:0] >> F;

    // saturating truncated product
    msat_c = (|mul_rsp.prod[127:64]) || ((mul_rsp.prod[63:0] >> F) > MagCap);
    mval_c = msat_c ? MagCap : (mul_rsp.prod[63:0] >> F);

    diff_c = $signed(mval_c) - $signed(q3_q);
    sum_c  = 49'(sum_q) + 49'(term_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lje_pkg::ST_IDLE: begin
        if (accept && (cmd_i == lje_pkg::CMD_QUERY)) begin
          state_d = (idx_ok && written_q[in_idx]) ? lje_pkg::ST_LOADI : lje_pkg::ST_OUT;
        end
      end
      lje_pkg::ST_LOADI: state_d = lje_pkg::ST_FETCH;
      lje_pkg::ST_FETCH: begin
        if (j_end) begin
          state_d = lje_pkg::ST_OUT;
        end else if (!j_skip) begin
          state_d = lje_pkg::ST_AXIS;
        end
      end
      lje_pkg::ST_AXIS: begin
        state_d = (box_q == '0) ? lje_pkg::ST_WAIT_SQ : lje_pkg::ST_WAIT_N;
      end
      lje_pkg::ST_WAIT_N:  if (mul_rsp.done) state_d = lje_pkg::ST_WAIT_NB;
      lje_pkg::ST_WAIT_NB: if (mul_rsp.done) state_d = lje_pkg::ST_WAIT_SQ;
      lje_pkg::ST_WAIT_SQ: begin
        if (mul_rsp.done) begin
          state_d = (k_q == 2'd2) ? lje_pkg::ST_CUT : lje_pkg::ST_AXIS;
        end
      end
      lje_pkg::ST_CUT: begin
        if (r2_q >= 64'(cut_q)) begin
          state_d = lje_pkg::ST_FETCH;
        end else if (r2_q == '0) begin
          state_d = lje_pkg::ST_ACC;
        end else begin
          state_d = lje_pkg::ST_WAIT_DIV;
        end
      end
      lje_pkg::ST_WAIT_DIV: if (div_rsp.done) state_d = lje_pkg::ST_WAIT_Q2;
      lje_pkg::ST_WAIT_Q2:  if (mul_rsp.done) state_d = lje_pkg::ST_WAIT_Q3;
      lje_pkg::ST_WAIT_Q3:  if (mul_rsp.done) state_d = lje_pkg::ST_WAIT_Q6;
      lje_pkg::ST_WAIT_Q6:  if (mul_rsp.done) state_d = lje_pkg::ST_ACC;
      lje_pkg::ST_ACC:      state_d = lje_pkg::ST_FETCH;
      lje_pkg::ST_OUT:      if (!out_stall_i) state_d = lje_pkg::ST_IDLE;
      default:              state_d = lje_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit requests
  always_comb begin
    in_stall_o      = state_q != lje_pkg::ST_IDLE;
    out_valid_o     = state_q == lje_pkg::ST_OUT;
    rd_en           = 1'b0;
    rd_addr         = j_q[IW-1:0];
    mul_req.start   = 1'b0;
    mul_req.a       = '0;
    mul_req.b       = '0;
    div_req.start   = 1'b0;
    div_req.divisor = r2_q;
    unique case (state_q)
      lje_pkg::ST_IDLE: begin
        rd_en   = accept && (cmd_i == lje_pkg::CMD_QUERY);
        rd_addr = in_idx;
      end
      lje_pkg::ST_FETCH: rd_en = 1'b1;
      lje_pkg::ST_AXIS: begin
        mul_req.start = 1'b1;
        mul_req.a     = 64'(dmag_c);
        mul_req.b     = (box_q == '0) ? 64'(dmag_c) : 64'(inv_q);
      end
      lje_pkg::ST_WAIT_N: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = n_c;
        mul_req.b     = 64'(box_q);
      end
      lje_pkg::ST_WAIT_NB: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = mag_c;
        mul_req.b     = mag_c;
      end
      lje_pkg::ST_CUT: begin
        div_req.start = (r2_q < 64'(cut_q)) && (r2_q != '0);
      end
      lje_pkg::ST_WAIT_DIV: begin
        mul_req.start = div_rsp.done;
        mul_req.a     = div_rsp.quotient;
        mul_req.b     = div_rsp.quotient;
      end
      lje_pkg::ST_WAIT_Q2: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = mval_c;
        mul_req.b     = q_q;
      end
      lje_pkg::ST_WAIT_Q3: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = mval_c;
        mul_req.b     = mval_c;
      end
      default: ;
    endcase
  end

  assign particle_energy_o  = sum_q;
  assign energy_saturated_o = flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lje_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      flag_q <= 1'b0;
    end else begin
      case (state_q)
        lje_pkg::ST_IDLE: begin
          if (accept && (cmd_i == lje_pkg::CMD_QUERY)) begin
            sum_q  <= '0;
            flag_q <= 1'b0;
          end
        end
        lje_pkg::ST_CUT: begin
          if ((r2_q < 64'(cut_q)) && (r2_q == '0)) begin
            flag_q <= 1'b1;
          end
        end
        lje_pkg::ST_WAIT_Q6: begin
          if (mul_rsp.done && (sat_q || msat_c || (diff_c > DiffMax) || (diff_c < DiffMin))) begin
            flag_q <= 1'b1;
          end
        end
        lje_pkg::ST_ACC: begin
          if (sum_c[48] != sum_c[47]) begin
            sum_q  <= sum_c[48] ? lje_pkg::E_MIN : lje_pkg::E_MAX;
            flag_q <= 1'b1;
          end else begin
            sum_q <= sum_c[47:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lje_pkg::ST_IDLE: begin
        idx_q <= in_idx;
        j_q   <= '0;
      end
      lje_pkg::ST_LOADI: pi_q <= rd_q;
      lje_pkg::ST_FETCH: begin
        k_q  <= 2'd0;
        r2_q <= '0;
        if (!j_end && j_skip) begin
          j_q <= j_q + 1'b1;
        end
      end
      lje_pkg::ST_AXIS: d_q <= d_c;
      lje_pkg::ST_WAIT_SQ: begin
        if (mul_rsp.done) begin
          r2_q <= r2_q + sq_c;
          k_q  <= k_q + 1'b1;
        end
      end
      lje_pkg::ST_CUT: begin
        sat_q  <= 1'b0;
        term_q <= lje_pkg::E_MAX;
        if (r2_q >= 64'(cut_q)) begin
          j_q <= j_q + 1'b1;
        end
      end
      lje_pkg::ST_WAIT_DIV: if (div_rsp.done) q_q <= div_rsp.quotient;
      lje_pkg::ST_WAIT_Q2:  if (mul_rsp.done) sat_q <= msat_c;
      lje_pkg::ST_WAIT_Q3: begin
        if (mul_rsp.done) begin
          q3_q  <= mval_c;
          sat_q <= sat_q | msat_c;
        end
      end
      lje_pkg::ST_WAIT_Q6: begin
        if (mul_rsp.done) begin
          if (sat_q || msat_c || (diff_c > DiffMax)) begin
            term_q <= lje_pkg::E_MAX;
          end else if (diff_c < DiffMin) begin
            term_q <= lje_pkg::E_MIN;
          end else begin
            term_q <= {diff_c[45:0], 2'b00};
          end
        end
      end
      lje_pkg::ST_ACC: j_q <= j_q + 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: test/lennard_jones_particle_energy_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lennard_jones_particle_energy_tb: self-checking bench for the LJ energy block
// Drives position writes and energy queries through the valid/stall ports,
// predicts each query's energy and flag in a scoreboard and compares results.
// ----------------------------------------------------------------------------
module lennard_jones_particle_energy_tb;

  localparam int  NPART     = 256;
  localparam int  FB        = 16;
  localparam int  ONE       = 1 << FB;
  localparam int  LIMIT     = 3_000_000;
  localparam int  HOLD_LEN  = 400;
  localparam longint EMAX_L = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint EMIN_L = -EMAX_L - 1;
  localparam longint unsigned CAP = 64'd1 << 62;

  typedef struct {
    logic signed [47:0] energy;
    logic               sat;
  } energy_res_t;

  // --------------------------------------------------------------------------
  // Energy scoreboard: shadow registers and position store, expected results
  // --------------------------------------------------------------------------
  class energy_board;
    longint unsigned box, inv_box, cut_sq, count;
    longint          pos[NPART][3];
    bit              seen[NPART];
    energy_res_t     pending[$];
    int              errors;

    function new();
      box = 0; inv_box = 0; cut_sq = 0; count = 0; errors = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [30:0] val);
      case (idx)
        lje_pkg::REG_BOX_LENGTH:     box = val;
        lje_pkg::REG_INV_BOX_LENGTH: inv_box = val;
        lje_pkg::REG_CUTOFF_SQ:      cut_sq = val;
        lje_pkg::REG_PARTICLE_COUNT: count = val[8:0];
        default: ;
      endcase
    endfunction

    // folded, clamped, squared axis distance
    function longint unsigned axis_dist_sq(longint d);
      bit neg;
      longint unsigned mag, n;
      longint nb, f;
      neg = d < 0;
      mag = neg ? -d : d;
      if (box != 0) begin
        n = (mag * inv_box + (64'd1 << (2 * FB - 1))) >> (2 * FB);
        if (n > 64'h1_0000_0000) n = 64'h1_0000_0000;
        nb = n * box;
        f = neg ? d + nb : d - nb;
        mag = f < 0 ? -f : f;
      end
      if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
      return (mag * mag) >> FB;
    endfunction

    function longint unsigned mul_clamp(longint unsigned a, longint unsigned b,
                                        inout bit sat);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      if (p[127:64] != 0 || (p >> FB) > CAP) begin
        sat = 1;
        return CAP;
      end
      return p[63+FB:FB];
    endfunction

    function longint lj_term(longint unsigned r2, inout bit flag);
      bit sat;
      longint unsigned q, q2, q3, q6;
      longint diff;
      sat = 0;
      if (r2 == 0) begin
        flag = 1;
        return EMAX_L;
      end
      q  = (64'd1 << (2 * FB)) / r2;
      q2 = mul_clamp(q, q, sat);
      q3 = mul_clamp(q2, q, sat);
      q6 = mul_clamp(q3, q3, sat);
      if (sat) begin
        flag = 1;
        return EMAX_L;
      end
      diff = longint'(q6) - longint'(q3);
      if (diff > EMAX_L / 4) begin
        flag = 1;
        return EMAX_L;
      end
      if (diff < EMIN_L / 4) begin
        flag = 1;
        return EMIN_L;
      end
      return diff * 4;
    endfunction

    // note an accepted input item
    function void note_item(logic cmd, logic [7:0] idx, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] z);
      energy_res_t r;
      longint sum, t, s;
      longint unsigned r2, lim;
      bit flag;
      if (cmd == lje_pkg::CMD_WRITE) begin
        pos[idx][0] = x; pos[idx][1] = y; pos[idx][2] = z;
        seen[idx] = 1;
        return;
      end
      sum = 0; flag = 0;
      if (seen[idx]) begin
        lim = count > NPART ? NPART : count;
        for (int j = 0; j < lim; j++) begin
          if (j == idx || !seen[j]) continue;
          r2 = 0;
          for (int k = 0; k < 3; k++) r2 += axis_dist_sq(pos[idx][k] - pos[j][k]);
          if (r2 >= cut_sq) continue;
          t = lj_term(r2, flag);
          s = sum + t;
          if (s > EMAX_L) begin
            s = EMAX_L; flag = 1;
          end else if (s < EMIN_L) begin
            s = EMIN_L; flag = 1;
          end
          sum = s;
        end
      end
      r.energy = sum[47:0];
      r.sat = flag;
      pending.insert(pending.size(), r);
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic signed [47:0] e, logic s);
      energy_res_t w;
      if (pending.size() == 0) begin
        report("unexpected result, energy", e, 0);
        return;
      end
      w = pending.pop_front();
      if (e !== w.energy) report("particle_energy", e, w.energy);
      if (s !== w.sat) report("energy_saturated", s, w.sat);
    endtask
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we_i = 0;
  logic [1:0]         cfg_idx_i = '0;
  logic [30:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic               cmd_i = 0;
  logic [7:0]         particle_index_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [47:0] particle_energy_o;
  logic               energy_saturated_o;

  energy_board board = new();
  int  send_idle_pct = 0, recv_stall_pct = 0;
  bit  hold_go = 0;
  int  hold_left = 0;
  int  cycles = 0;

  lennard_jones_particle_energy u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("lennard_jones_particle_energy test failed");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HOLD_LEN;
      hold_go = 0;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // result monitor
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(particle_energy_o, energy_saturated_o);

  // register write; call at a falling edge
  task write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 0;
    @(negedge clk_i);
  endtask

  task set_regs(logic [30:0] bx, logic [30:0] inv, logic [30:0] cut, logic [8:0] n);
    write_reg(lje_pkg::REG_BOX_LENGTH, bx);
    write_reg(lje_pkg::REG_INV_BOX_LENGTH, inv);
    write_reg(lje_pkg::REG_CUTOFF_SQ, cut);
    write_reg(lje_pkg::REG_PARTICLE_COUNT, 31'(n));
  endtask

  // offer one item until accepted; enters and leaves at a falling edge
  task send_item(logic cmd, logic [7:0] idx, logic signed [31:0] x,
                 logic signed [31:0] y, logic signed [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1; cmd_i <= cmd; particle_index_i <= idx;
    pos_x_i <= x; pos_y_i <= y; pos_z_i <= z;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
      @(negedge clk_i);
    end
    board.note_item(cmd, idx, x, y, z);
    @(negedge clk_i);
  endtask

  task put_pos(logic [7:0] idx, int x, int y, int z);
    send_item(lje_pkg::CMD_WRITE, idx, x, y, z);
  endtask

  task ask_energy(logic [7:0] idx);
    send_item(lje_pkg::CMD_QUERY, idx, $urandom, $urandom, $urandom);
  endtask

  // let every expected result drain, then a margin for a trailing write
  task drain();
    in_valid_i <= 0;
    @(negedge clk_i);
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // positions near the origin in most writes, anywhere in the rest
  function int rand_coord();
    if ($urandom_range(9) < 7) return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
    return $urandom;
  endfunction

  task random_phase(int items, int max_idx, bit with_hold);
    for (int i = 0; i < items; i++) begin
      logic [7:0] idx;
      idx = ($urandom_range(9) < 8) ? 8'($urandom_range(max_idx)) : 8'($urandom);
      if (with_hold && i == items / 2) hold_go = 1;
      if ($urandom_range(1)) put_pos(idx, rand_coord(), rand_coord(), rand_coord());
      else ask_energy(idx);
    end
    drain();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed part
    send_idle_pct = 8; recv_stall_pct = 51;
    set_regs(0, 0, 31'h7FFF_FFFF, 4);
    put_pos(0, 0, 0, 0);
    put_pos(1, ONE, 0, 0);           // unit distance: energy zero
    ask_energy(0);
    ask_energy(9);                   // never written: zero result
    put_pos(2, 0, 0, 0);             // coincident with particle 0
    ask_energy(0);
    put_pos(3, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    ask_energy(3);
    put_pos(10, ONE / 2, ONE, 0);    // index above count still computes
    ask_energy(10);
    drain();
    set_regs(31'(10 * ONE), 31'(ONE / 10 + 1), 31'h7FFF_FFFF, 4);  // folded box
    put_pos(1, 9 * ONE, ONE / 3, -ONE);
    ask_energy(1);
    ask_energy(2);
    drain();
    set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 4);  // inconsistent box, zero cutoff
    ask_energy(0);
    drain();
    set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 4);
    ask_energy(3);
    put_pos(1, 0, 0, 0);             // two coincident partners: sum clamps
    ask_energy(0);
    drain();
    set_regs(0, 0, 31'h7FFF_FFFF, 0);  // empty count
    ask_energy(0);
    drain();

    // random part, three idle mixes
    set_regs(0, 0, 31'($urandom_range(ONE, 40 * ONE)), 12);
    random_phase(34, 11, 1'b0);

    send_idle_pct = 51; recv_stall_pct = 8;
    set_regs(31'(8 * ONE), 31'(ONE / 8), 31'($urandom), 10);
    random_phase(34, 11, 1'b1);

    send_idle_pct = 0; recv_stall_pct = 0;
    set_regs(31'($urandom_range(2 * ONE, 20 * ONE)), 31'($urandom_range(3000, 40000)),
             31'($urandom_range(ONE, 60 * ONE)), 9);
    random_phase(30, 8, 1'b1);

    // count above the store size: whole store walked
    set_regs(0, 0, 31'h7FFF_FFFF, 9'd511);
    ask_energy(0);
    ask_energy(10);
    drain();

    repeat (50) @(negedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("lennard_jones_particle_energy test passed");
    else
      $display("lennard_jones_particle_energy test failed");
    $finish;
  end

endmodule
